FILE: rtl/bdar_pkg.sv
// bdar_pkg: shared types and constants for the button debounce / auto-repeat block
// used by bdar_lane, bdar_merge and button_debounce_autorepeat; no dependencies
package bdar_pkg;

	localparam int FIELD_W = 4;   // width of raw_levels, clear_mask and both result fields
	localparam int DELAY_W = 10;  // width of the delay registers and hold countdowns
	localparam int CFG_IDX_W = 2;

	localparam logic [DELAY_W-1:0] RESET_FIRST_DELAY  = 10'd300;
	localparam logic [DELAY_W-1:0] RESET_REPEAT_DELAY = 10'd100;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY = 2'd1;

	// per-button result handed from a lane to the merge stage
	typedef struct packed {
		logic pending;
		logic press_event;
	} lane_res_t;

	// delay settings shared by all lanes
	typedef struct packed {
		logic [DELAY_W-1:0] first_delay;
		logic [DELAY_W-1:0] repeat_delay;
	} delay_cfg_t;

endpackage

FILE: rtl/bdar_lane.sv
// bdar_lane: one button's three-sample debounce, press flag and hold countdown
// depends on bdar_pkg
module bdar_lane (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic                  level,
	input  logic                  clear,
	input  bdar_pkg::delay_cfg_t  cfg,
	output bdar_pkg::lane_res_t   res
);

	logic                          s_mid_q, s_new_q;
	logic                          acc_q, held_long_q, flag_q;
	logic [bdar_pkg::DELAY_W-1:0]  cnt_q;

	logic                          stable;
	logic                          acc_d, held_long_d, flag_d, event_d;
	logic [bdar_pkg::DELAY_W-1:0]  cnt_d;

	// window after this tick's sample shifts in: s_mid_q, s_new_q, level
	assign stable = (s_mid_q == s_new_q) && (s_new_q == level);

	always_comb begin
		acc_d       = acc_q;
		cnt_d       = cnt_q;
		held_long_d = held_long_q;
		flag_d      = flag_q;
		event_d     = 1'b0;
		if (stable) begin
			if (level != acc_q) begin
				acc_d = level;
				if (!level) begin
					cnt_d   = held_long_q ? cfg.repeat_delay : cfg.first_delay;
					flag_d  = 1'b1;
					event_d = 1'b1;
				end else begin
					held_long_d = 1'b0;
				end
			end else if (!acc_q) begin
				// held and stable: count down, force a release at zero to re-arm
				cnt_d = cnt_q - bdar_pkg::DELAY_W'(1);
				if (cnt_d == '0) begin
					acc_d       = 1'b1;
					held_long_d = 1'b1;
				end
			end
		end
	end

	assign res.pending     = flag_d;
	assign res.press_event = event_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_mid_q     <= 1'b1;
			s_new_q     <= 1'b1;
			acc_q       <= 1'b1;
			cnt_q       <= bdar_pkg::RESET_FIRST_DELAY;
			held_long_q <= 1'b0;
			flag_q      <= 1'b0;
		end else if (accept) begin
			s_mid_q     <= s_new_q;
			s_new_q     <= level;
			acc_q       <= acc_d;
			cnt_q       <= cnt_d;
			held_long_q <= held_long_d;
			// flag is reported before the clear takes effect
			flag_q      <= flag_d & ~clear;
		end
	end

endmodule

FILE: rtl/bdar_merge.sv
// bdar_merge: gathers the lane results into the output register
// depends on bdar_pkg
module bdar_merge #(
	parameter int LANES = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  bdar_pkg::lane_res_t           res [LANES],
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [bdar_pkg::FIELD_W-1:0]  pending_flags,
	output logic [bdar_pkg::FIELD_W-1:0]  press_events
);

	logic                          valid_q;
	logic [bdar_pkg::FIELD_W-1:0]  pend_q, evt_q;
	logic [bdar_pkg::FIELD_W-1:0]  pend_d, evt_d;

	always_comb begin
		pend_d = '0;
		evt_d  = '0;
		for (int i = 0; i < LANES; i++) begin
			pend_d[i] = res[i].pending;
			evt_d[i]  = res[i].press_event;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pend_q <= pend_d;
			evt_q  <= evt_d;
		end
	end

	assign out_valid     = valid_q;
	assign pending_flags = pend_q;
	assign press_events  = evt_q;

endmodule

FILE: rtl/button_debounce_autorepeat.sv
// button_debounce_autorepeat: debounce, press latching and auto-repeat for a row of buttons
// depends on bdar_pkg, bdar_lane, bdar_merge
//
//  channel  handshake            payload
//  in       in_valid / in_stall  raw_levels, clear_mask
//  out      out_valid/ out_stall pending_flags, press_events
//  cfg      cfg_valid/ cfg_ready cfg_index, cfg_data
//
// one tick per cycle while the input is not stalled: every lane updates at the input
// transaction and the output register loads the result at that same transaction
// the only stall source is a full output register held by out_stall
// reset puts all samples at released, countdowns at 300, flags and delays at defaults
// cfg_ready is always high; writes to indexes other than 0 and 1 are dropped
module button_debounce_autorepeat #(
	parameter int NUM_BUTTONS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [bdar_pkg::FIELD_W-1:0]    raw_levels,
	input  logic [bdar_pkg::FIELD_W-1:0]    clear_mask,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [bdar_pkg::FIELD_W-1:0]    pending_flags,
	output logic [bdar_pkg::FIELD_W-1:0]    press_events,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bdar_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bdar_pkg::DELAY_W-1:0]    cfg_data
);

	// buttons beyond the field width never see input and never reach an output
	localparam int LANES = (NUM_BUTTONS < bdar_pkg::FIELD_W) ? NUM_BUTTONS : bdar_pkg::FIELD_W;

	logic                  accept;
	bdar_pkg::delay_cfg_t  cfg_q;
	bdar_pkg::lane_res_t   res [LANES];

	assign in_stall  = out_valid && out_stall;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_delay  <= bdar_pkg::RESET_FIRST_DELAY;
			cfg_q.repeat_delay <= bdar_pkg::RESET_REPEAT_DELAY;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bdar_pkg::REG_FIRST_DELAY:  cfg_q.first_delay  <= cfg_data;
				bdar_pkg::REG_REPEAT_DELAY: cfg_q.repeat_delay <= cfg_data;
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		bdar_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.accept (accept),
			.level  (raw_levels[i]),
			.clear  (clear_mask[i]),
			.cfg    (cfg_q),
			.res    (res[i])
		);
	end

	bdar_merge #(
		.LANES (LANES)
	) u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (accept),
		.res           (res),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.pending_flags (pending_flags),
		.press_events  (press_events)
	);

	// a press event always latches its flag in the same tick
	a_event_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((press_events & ~pending_flags) == '0))
		else $error("press event without pending flag");

	// every input transaction produces a result next cycle
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("input transaction lost its result");

	// an empty output register never back-pressures the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output register");

endmodule
